>>> hw/rtl/heading_pid_turn_controller_assert.svh
// assertion macros for the heading turn controller
`ifndef HEADING_PID_TURN_CONTROLLER_ASSERT_SVH
`define HEADING_PID_TURN_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define HPTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hptc_pkg.sv
// types and constants of the heading turn controller
package hptc_pkg;

  localparam int GYRO_W     = 12;
  localparam int POWER_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HEADING,
    CFG_SPEED_LIMIT,
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_INTEG_WINDOW,
    CFG_INTEG_CAP
  } cfg_idx_e;

  localparam logic signed [17:0] TARGET_RST = 18'sd0;
  localparam logic [6:0]         SPEED_RST  = 7'd60;
  localparam logic [22:0]        PGAIN_RST  = 23'd45875;
  localparam logic [16:0]        IGAIN_RST  = 17'd262;
  localparam logic [22:0]        DGAIN_RST  = 23'd1966;
  localparam logic [15:0]        WINDOW_RST = 16'd6400;
  localparam logic [14:0]        CAP_RST    = 15'd3840;

  localparam logic signed [19:0] PREV_ERR_RST = 20'sd25600;
  localparam logic [20:0]        HALF_TURN    = 21'd46080;
  localparam logic signed [20:0] FULL_TURN    = 21'sd92160;
  localparam logic [19:0]        SETTLE_TOL   = 20'd25;

  // reciprocal multipliers for the constant divides
  localparam logic [15:0] DIV20_MUL   = 16'd3277;
  localparam int          DIV20_SHIFT = 16;
  localparam logic [17:0] DIV15_MUL   = 18'd139811;
  localparam int          DIV15_SHIFT = 21;

  localparam int GAIN_SHIFT = 16;

endpackage

>>> hw/rtl/hptc_in_if.sv
// input channel of the heading turn controller
interface hptc_in_if;
  logic                          valid;
  logic                          ready;
  logic [hptc_pkg::GYRO_W-1:0]   gyro_main;
  logic [hptc_pkg::GYRO_W-1:0]   gyro_inverted;
  logic                          begin_req;

  modport source (output valid, gyro_main, gyro_inverted, begin_req, input ready);
  modport sink   (input valid, gyro_main, gyro_inverted, begin_req, output ready);
endinterface

>>> hw/rtl/hptc_out_if.sv
// result channel of the heading turn controller
interface hptc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hptc_pkg::POWER_W-1:0]  left_power;
  logic signed [hptc_pkg::POWER_W-1:0]  right_power;
  logic                                 settled;

  modport source (output valid, left_power, right_power, settled, input ready);
  modport sink   (input valid, left_power, right_power, settled, output ready);
endinterface

>>> hw/rtl/heading_pid_turn_controller.sv
// heading pid turn controller: seven-register pipeline with integral clamp
//
//   channel   dir  payload                                    handshake
//   in_ch     in   gyro_main, gyro_inverted, begin_req        valid/ready
//   out_ch    out  left_power, right_power, settled           valid/ready
//   cfg       in   cfg_idx_i, cfg_data_i                      cfg_we_i, no wait
//
// one word per cycle unless out_ch.ready stalls; a result is valid once its word reaches register 6
// the error state updates as a word moves into register 3, the integral into register 5
// each register fills while any later one drains; ready drops only when all are full
// reset loads the register defaults and presets the last error to 100 degrees
`include "heading_pid_turn_controller_assert.svh"

module heading_pid_turn_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hptc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hptc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hptc_in_if.sink                           in_ch,
  hptc_out_if.source                        out_ch
);

  // configuration
  logic signed [17:0] target_q;
  logic [6:0]         speed_q;
  logic [22:0]        pgain_q;
  logic [16:0]        igain_q;
  logic [22:0]        dgain_q;
  logic [15:0]        window_q;
  logic [14:0]        cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= hptc_pkg::TARGET_RST;
      speed_q  <= hptc_pkg::SPEED_RST;
      pgain_q  <= hptc_pkg::PGAIN_RST;
      igain_q  <= hptc_pkg::IGAIN_RST;
      dgain_q  <= hptc_pkg::DGAIN_RST;
      window_q <= hptc_pkg::WINDOW_RST;
      cap_q    <= hptc_pkg::CAP_RST;
    end else if (cfg_we_i) begin
      unique case (hptc_pkg::cfg_idx_e'(cfg_idx_i))
        hptc_pkg::CFG_TARGET_HEADING: target_q <= $signed(cfg_data_i[17:0]);
        hptc_pkg::CFG_SPEED_LIMIT:    speed_q  <= cfg_data_i[6:0];
        hptc_pkg::CFG_PROP_GAIN:      pgain_q  <= cfg_data_i[22:0];
        hptc_pkg::CFG_INTEG_GAIN:     igain_q  <= cfg_data_i[16:0];
        hptc_pkg::CFG_DERIV_GAIN:     dgain_q  <= cfg_data_i[22:0];
        hptc_pkg::CFG_INTEG_WINDOW:   window_q <= cfg_data_i[15:0];
        hptc_pkg::CFG_INTEG_CAP:      cap_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [6:0] v_q;
  logic [7:0] rdy;

  always_comb begin
    rdy[7] = out_ch.ready;
    for (int k = 6; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy[6:0]) | ({v_q[5:0], in_ch.valid} & rdy[6:0]);
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = v_q[6];

  // register 0: input word
  logic [hptc_pkg::GYRO_W-1:0] g1_q, g2_q;
  logic                        beg0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      g1_q   <= in_ch.gyro_main;
      g2_q   <= in_ch.gyro_inverted;
      beg0_q <= in_ch.begin_req;
    end
  end

  // stage 1: heading in whole degrees and scaled target
  logic signed [12:0] gdiff;
  logic [11:0]        gmag;
  logic [27:0]        gprod;
  logic [7:0]         hmag;
  logic signed [8:0]  hq_d;
  logic [17:0]        tmag;
  logic [35:0]        tprod;
  logic [17:0]        tq;
  logic [17:0]        tsmag;
  logic signed [18:0] ts_d;

  always_comb begin
    gdiff = $signed({1'b0, g1_q}) - $signed({1'b0, g2_q});
    gmag  = gdiff[12] ? 12'(-gdiff) : 12'(gdiff);
    gprod = gmag * hptc_pkg::DIV20_MUL;
    hmag  = 8'(gprod >> hptc_pkg::DIV20_SHIFT);
    hq_d  = gdiff[12] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
    // 16/15 of the magnitude is m + m/15
    tmag  = target_q[17] ? 18'(-target_q) : 18'(target_q);
    tprod = tmag * hptc_pkg::DIV15_MUL;
    tq    = 18'(tprod >> hptc_pkg::DIV15_SHIFT);
    tsmag = tmag + tq;
    ts_d  = target_q[17] ? -$signed({1'b0, tsmag}) : $signed({1'b0, tsmag});
  end

  logic signed [8:0]  hq1_q;
  logic signed [18:0] ts1_q;
  logic               beg1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      hq1_q  <= hq_d;
      ts1_q  <= ts_d;
      beg1_q <= beg0_q;
    end
  end

  // stage 2: error and half-turn fold
  logic signed [20:0] e_raw;
  logic [20:0]        e_rmag;
  logic signed [20:0] fold_mag;
  logic signed [20:0] e_fold;
  logic signed [19:0] e_d;

  always_comb begin
    e_raw    = 21'(ts1_q) - 21'($signed({hq1_q, 8'd0}));
    e_rmag   = e_raw[20] ? 21'(-e_raw) : 21'(e_raw);
    fold_mag = hptc_pkg::FULL_TURN - $signed(e_rmag);
    e_fold   = e_raw[20] ? -fold_mag : fold_mag;
    e_d      = (e_rmag > hptc_pkg::HALF_TURN) ? 20'(e_fold) : 20'(e_raw);
  end

  logic signed [19:0] e2_q;
  logic               beg2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      e2_q   <= e_d;
      beg2_q <= beg1_q;
    end
  end

  // stage 3: last error, settle test and the finished flag
  logic signed [19:0] prev_q;
  logic               fin_q;
  logic               fin_eff;
  logic signed [19:0] last;
  logic [19:0]        emag3, lmag3, prev_mag;
  logic               hit;
  logic               upd3;
  logic signed [20:0] diff_d;

  always_comb begin
    fin_eff  = fin_q && !beg2_q;
    last     = beg2_q ? hptc_pkg::PREV_ERR_RST : prev_q;
    emag3    = e2_q[19] ? 20'(-e2_q) : 20'(e2_q);
    lmag3    = last[19] ? 20'(-last) : 20'(last);
    prev_mag = prev_q[19] ? 20'(-prev_q) : 20'(prev_q);
    hit      = (emag3 <= hptc_pkg::SETTLE_TOL) && (lmag3 <= hptc_pkg::SETTLE_TOL);
    diff_d   = 21'(e2_q) - 21'(last);
    upd3     = v_q[2] && rdy[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= hptc_pkg::PREV_ERR_RST;
      fin_q  <= 1'b0;
    end else if (upd3) begin
      if (!fin_eff) begin
        prev_q <= e2_q;
      end
      fin_q <= fin_eff || hit;
    end
  end

  logic signed [19:0] e3_q;
  logic signed [20:0] diff3_q;
  logic               skip3_q, settle3_q, beg3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      e3_q      <= e2_q;
      diff3_q   <= diff_d;
      skip3_q   <= fin_eff;
      settle3_q <= fin_eff || hit;
      beg3_q    <= beg2_q;
    end
  end

  // stage 4: gain products, truncated toward zero
  logic signed [43:0] pprod, pbias;
  logic signed [44:0] dprod, dbias;
  logic signed [37:0] iprod, ibias;
  logic [19:0]        emag4;

  always_comb begin
    pprod = e3_q * $signed({1'b0, pgain_q});
    dprod = diff3_q * $signed({1'b0, dgain_q});
    iprod = e3_q * $signed({1'b0, igain_q});
    pbias = pprod[43] ? pprod + 44'sd65535 : pprod;
    dbias = dprod[44] ? dprod + 45'sd65535 : dprod;
    ibias = iprod[37] ? iprod + 38'sd65535 : iprod;
    emag4 = e3_q[19] ? 20'(-e3_q) : 20'(e3_q);
  end

  logic signed [25:0] p4_q;
  logic signed [26:0] d4_q;
  logic signed [19:0] i4_q;
  logic               win4_q, epos4_q, skip4_q, settle4_q, beg4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      p4_q      <= 26'(pbias >>> hptc_pkg::GAIN_SHIFT);
      d4_q      <= 27'(dbias >>> hptc_pkg::GAIN_SHIFT);
      i4_q      <= 20'(ibias >>> hptc_pkg::GAIN_SHIFT);
      win4_q    <= emag4 < 20'(window_q);
      epos4_q   <= !e3_q[19] && (e3_q != '0);
      skip4_q   <= skip3_q;
      settle4_q <= settle3_q;
      beg4_q    <= beg3_q;
    end
  end

  // stage 5: integral with window and cap, then the sum of terms
  logic signed [23:0] integ_q;
  logic signed [23:0] ibase;
  logic signed [24:0] isum;
  logic [24:0]        imag;
  logic signed [23:0] cap_s;
  logic signed [23:0] inew;
  logic signed [27:0] pd;
  logic signed [28:0] power_d;
  logic               upd5;
  logic [23:0]        integ_mag;

  always_comb begin
    ibase     = beg4_q ? 24'sd0 : integ_q;
    isum      = 25'(ibase) + (win4_q ? 25'(i4_q) : 25'sd0);
    imag      = isum[24] ? 25'(-isum) : 25'(isum);
    cap_s     = $signed({9'd0, cap_q});
    if (imag > 25'(cap_q)) begin
      inew = epos4_q ? cap_s : -cap_s;
    end else begin
      inew = 24'(isum);
    end
    pd        = 28'(p4_q) + 28'(d4_q);
    power_d   = 29'(pd) + 29'(inew);
    upd5      = v_q[4] && rdy[5];
    integ_mag = integ_q[23] ? 24'(-integ_q) : 24'(integ_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= 24'sd0;
    end else if (upd5 && !skip4_q) begin
      integ_q <= inew;
    end
  end

  logic signed [28:0] pw5_q;
  logic               settle5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      pw5_q     <= power_d;
      settle5_q <= settle4_q;
    end
  end

  // stage 6: speed limit and result word
  logic [14:0]        lim;
  logic signed [15:0] lim_s;
  logic [28:0]        pmag;
  logic signed [15:0] sat;

  always_comb begin
    lim   = {speed_q, 8'd0};
    lim_s = $signed({1'b0, lim});
    pmag  = pw5_q[28] ? 29'(-pw5_q) : 29'(pw5_q);
    if (pmag > 29'(lim)) begin
      sat = (!pw5_q[28] && (pw5_q != '0)) ? lim_s : -lim_s;
    end else begin
      sat = 16'(pw5_q);
    end
  end

  logic signed [15:0] left_q, right_q;
  logic               settled_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      left_q    <= settle5_q ? 16'sd0 : sat;
      right_q   <= settle5_q ? 16'sd0 : -sat;
      settled_q <= settle5_q;
    end
  end

  assign out_ch.left_power  = left_q;
  assign out_ch.right_power = right_q;
  assign out_ch.settled     = settled_q;

  `HPTC_ASSERT_NOW(a_settled_zero, out_ch.valid && out_ch.settled,
    (out_ch.left_power == 16'sd0) && (out_ch.right_power == 16'sd0), "settled word with power")
  `HPTC_ASSERT_NOW(a_full_stall, !in_ch.ready, out_ch.valid && !out_ch.ready,
    "input held off with room in the pipeline")
  `HPTC_ASSERT_NEXT(a_prev_frozen, upd3 && fin_eff, $stable(prev_q),
    "last error moved after the turn finished")
  `HPTC_ASSERT_NOW(a_fin_prev_small, fin_q, prev_mag <= hptc_pkg::SETTLE_TOL,
    "finished with a large last error")
  `HPTC_ASSERT_NEXT(a_integ_capped, upd5 && !skip4_q, integ_mag <= 24'($past(cap_q)),
    "integral above its cap")

endmodule

>>> tb/heading_pid_turn_controller_test.sv
// self-checking bench for the heading turn controller: directed table, then random turns and words
`timescale 1ns / 1ps

module heading_pid_turn_controller_test;

  localparam int PIPE_LAT    = 7;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 192;
  localparam int MAX_DEG     = 204;

  typedef struct packed {
    logic signed [hptc_pkg::POWER_W-1:0] left_power;
    logic signed [hptc_pkg::POWER_W-1:0] right_power;
    logic                                settled;
  } drive_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                           kind;
    hptc_pkg::cfg_idx_e                  reg_idx;
    logic [hptc_pkg::CFG_DATA_W-1:0]     reg_val;
    logic [hptc_pkg::GYRO_W-1:0]         gm;
    logic [hptc_pkg::GYRO_W-1:0]         gi;
    logic                                beg;
    bit                                  typed;
    logic signed [hptc_pkg::POWER_W-1:0] left;
    logic                                settled;
  } plan_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [hptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [hptc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  hptc_in_if  in_ch ();
  hptc_out_if out_ch ();

  heading_pid_turn_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register copies
  logic signed [17:0] aim_q8;
  logic [6:0]         power_cap_pct;
  logic [22:0]        kp;
  logic [16:0]        ki;
  logic [22:0]        kd;
  logic [15:0]        integ_band;
  logic [14:0]        integ_limit;

  // controller state copies
  longint last_err_q8;
  longint integ_acc;
  bit     turn_done;

  drive_word_t pending_drive_q[$];
  plan_row_t   plan_rows[$];

  int errors;
  int words_sent;
  int results_checked;
  int settled_seen;
  int clipped_seen;
  int settings_used;
  int burst_left;

  function automatic longint mag_q(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint sgn_q(longint x);
    return (x > 0) ? 64'sd1 : -64'sd1;
  endfunction

  function automatic void apply_reg(hptc_pkg::cfg_idx_e idx,
                                    logic [hptc_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      hptc_pkg::CFG_TARGET_HEADING: aim_q8 = v[17:0];
      hptc_pkg::CFG_SPEED_LIMIT:    power_cap_pct = v[6:0];
      hptc_pkg::CFG_PROP_GAIN:      kp = v[22:0];
      hptc_pkg::CFG_INTEG_GAIN:     ki = v[16:0];
      hptc_pkg::CFG_DERIV_GAIN:     kd = v[22:0];
      hptc_pkg::CFG_INTEG_WINDOW:   integ_band = v[15:0];
      hptc_pkg::CFG_INTEG_CAP:      integ_limit = v[14:0];
      default: ;
    endcase
  endfunction

  function automatic drive_word_t drive_for_tick(logic [hptc_pkg::GYRO_W-1:0] gm,
                                                 logic [hptc_pkg::GYRO_W-1:0] gi,
                                                 logic beg);
    longint hdg, err, last, p_term, d_term, pw, lim;
    drive_word_t w;
    if (beg) begin
      integ_acc = 0;
      last_err_q8 = longint'(hptc_pkg::PREV_ERR_RST);
      turn_done = 1'b0;
    end
    if (turn_done) begin
      w = '{16'sd0, 16'sd0, 1'b1};
      return w;
    end
    hdg = ((longint'(gm) - longint'(gi)) / 20) * 256;
    err = (longint'(aim_q8) * 16) / 15 - hdg;
    if (mag_q(err) > longint'(hptc_pkg::HALF_TURN))
      err = sgn_q(err) * (longint'(hptc_pkg::FULL_TURN) - mag_q(err));
    last = last_err_q8;
    p_term = (err * longint'(kp)) / 65536;
    d_term = ((err - last) * longint'(kd)) / 65536;
    if (mag_q(err) < longint'(integ_band))
      integ_acc += (err * longint'(ki)) / 65536;
    if (mag_q(integ_acc) > longint'(integ_limit))
      integ_acc = longint'(integ_limit) * sgn_q(err);
    pw = p_term + integ_acc + d_term;
    last_err_q8 = err;
    if (mag_q(err) <= longint'(hptc_pkg::SETTLE_TOL) &&
        mag_q(last) <= longint'(hptc_pkg::SETTLE_TOL)) begin
      turn_done = 1'b1;
      w = '{16'sd0, 16'sd0, 1'b1};
      return w;
    end
    lim = longint'(power_cap_pct) * 256;
    if (mag_q(pw) > lim) begin
      pw = lim * sgn_q(pw);
      clipped_seen++;
    end
    w.left_power = 16'(pw);
    w.right_power = 16'(-pw);
    w.settled = 1'b0;
    return w;
  endfunction

  // gyro pair whose truncated difference / 20 gives the heading in degrees
  function automatic void pair_for(int h, output logic [hptc_pkg::GYRO_W-1:0] gm,
                                   output logic [hptc_pkg::GYRO_W-1:0] gi);
    int spare, off, diff;
    spare = 4095 - 20 * ((h < 0) ? -h : h);
    off = $urandom_range(0, (spare < 19) ? spare : 19);
    if (h > 0) diff = 20 * h + off;
    else if (h < 0) diff = 20 * h - off;
    else diff = $urandom_range(0, 1) ? off : -off;
    if (diff >= 0) begin
      gi = 12'($urandom_range(0, 4095 - diff));
      gm = 12'(int'(gi) + diff);
    end else begin
      gm = 12'($urandom_range(0, 4095 + diff));
      gi = 12'(int'(gm) - diff);
    end
  endfunction

  function automatic void row_word(logic [hptc_pkg::GYRO_W-1:0] gm,
                                   logic [hptc_pkg::GYRO_W-1:0] gi, logic beg);
    plan_row_t r;
    r = '{ROW_WORD, hptc_pkg::CFG_TARGET_HEADING, '0, gm, gi, beg, 1'b0, 16'sd0, 1'b0};
    plan_rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [hptc_pkg::GYRO_W-1:0] gm,
                                    logic [hptc_pkg::GYRO_W-1:0] gi, logic beg,
                                    logic signed [hptc_pkg::POWER_W-1:0] left,
                                    logic settled);
    plan_row_t r;
    r = '{ROW_WORD, hptc_pkg::CFG_TARGET_HEADING, '0, gm, gi, beg, 1'b1, left, settled};
    plan_rows.push_back(r);
  endfunction

  function automatic void row_reg(hptc_pkg::cfg_idx_e idx,
                                  logic [hptc_pkg::CFG_DATA_W-1:0] v);
    plan_row_t r;
    r = '{ROW_REG, idx, v, '0, '0, 1'b0, 1'b0, 16'sd0, 1'b0};
    plan_rows.push_back(r);
  endfunction

  function automatic int pick_aim();
    int jitter;
    jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 46) - 23 : 0;
    return ($urandom_range(0, 400) - 200) * 240 + jitter;
  endfunction

  function automatic logic [hptc_pkg::CFG_DATA_W-1:0] spread(int top_bit);
    return 23'($urandom_range(0, 1 << $urandom_range(0, top_bit)));
  endfunction

  task automatic settle_pipe();
    in_ch.valid = 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(hptc_pkg::cfg_idx_e idx, logic [hptc_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    apply_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_word(logic [hptc_pkg::GYRO_W-1:0] gm, logic [hptc_pkg::GYRO_W-1:0] gi,
                           logic beg, bit typed, drive_word_t typed_word);
    drive_word_t want;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      // hold off until the pipe is empty now and then
      if ($urandom_range(0, 59) == 0)
        while (pending_drive_q.size() != 0) @(negedge clk_i);
      if ($urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.gyro_main = gm;
    in_ch.gyro_inverted = gi;
    in_ch.begin_req = beg;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    want = drive_for_tick(gm, gi, beg);
    if (typed) want = typed_word;
    pending_drive_q.push_back(want);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_heading(int h, logic beg);
    logic [hptc_pkg::GYRO_W-1:0] gm, gi;
    pair_for(h, gm, gi);
    send_word(gm, gi, beg, 1'b0, '0);
  endtask

  task automatic configure_phase(int ph);
    int                              tgt;
    logic [6:0]                      sp;
    logic [hptc_pkg::CFG_DATA_W-1:0] kp_v, ki_v, kd_v;
    logic [15:0]                     band;
    logic [14:0]                     cap;
    case (ph)
      0: begin
        tgt = pick_aim(); sp = hptc_pkg::SPEED_RST; kp_v = hptc_pkg::PGAIN_RST;
        ki_v = 23'(hptc_pkg::IGAIN_RST); kd_v = hptc_pkg::DGAIN_RST;
        band = hptc_pkg::WINDOW_RST; cap = hptc_pkg::CAP_RST;
      end
      1: begin
        tgt = 0; sp = '0; kp_v = '0; ki_v = '0; kd_v = '0; band = '0; cap = '0;
      end
      2: begin
        tgt = 131071; sp = 7'h7F; kp_v = 23'h7FFFFF; ki_v = 23'h1FFFF;
        kd_v = 23'h7FFFFF; band = 16'hFFFF; cap = 15'h7FFF;
      end
      3: begin
        tgt = -92160; sp = 7'd100; kp_v = 23'd4194304; ki_v = 23'd65536;
        kd_v = 23'd4194304; band = 16'd46080; cap = 15'd25600;
      end
      4: begin
        tgt = -131072; sp = 7'($urandom); kp_v = 23'($urandom);
        ki_v = 23'($urandom & 32'h1FFFF); kd_v = 23'($urandom);
        band = 16'($urandom); cap = 15'($urandom);
      end
      default: begin
        tgt = pick_aim(); sp = 7'($urandom_range(0, 100)); kp_v = spread(22);
        ki_v = spread(16); kd_v = spread(22); band = 16'($urandom_range(0, 46080));
        cap = 15'($urandom_range(0, 25600));
      end
    endcase
    settle_pipe();
    write_reg(hptc_pkg::CFG_TARGET_HEADING, {5'd0, 18'(tgt)});
    write_reg(hptc_pkg::CFG_SPEED_LIMIT, {16'd0, sp});
    write_reg(hptc_pkg::CFG_PROP_GAIN, kp_v);
    write_reg(hptc_pkg::CFG_INTEG_GAIN, ki_v);
    write_reg(hptc_pkg::CFG_DERIV_GAIN, kd_v);
    write_reg(hptc_pkg::CFG_INTEG_WINDOW, {7'd0, band});
    write_reg(hptc_pkg::CFG_INTEG_CAP, {8'd0, cap});
    settings_used++;
  endtask

  // a turn: begin word, a ramp towards the goal heading, then a hold that may settle it
  task automatic run_turn(int goal);
    int start, steps, hold, h;
    start = $urandom_range(0, 2 * MAX_DEG) - MAX_DEG;
    steps = $urandom_range(1, 10);
    hold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
    send_heading(start, 1'b1);
    for (int i = 1; i <= steps; i++) begin
      h = start + ((goal - start) * i) / steps;
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2 * MAX_DEG) - MAX_DEG;
      send_heading(h, 1'b0);
    end
    repeat (hold) send_heading(goal, 1'b0);
  endtask

  task automatic run_phase(int count);
    int     first, goal;
    longint scaled;
    first = words_sent;
    scaled = (longint'(aim_q8) * 16) / 15;
    goal = int'((scaled + ((scaled >= 0) ? 128 : -128)) / 256);
    if (goal > MAX_DEG) goal = MAX_DEG;
    if (goal < -MAX_DEG) goal = -MAX_DEG;
    while (words_sent - first < count) begin
      if ($urandom_range(0, 3) == 0)
        send_word(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  ($urandom_range(0, 7) == 0), 1'b0, '0);
      else
        run_turn(goal);
    end
  endtask

  initial begin : stimulus
    plan_row_t   r;
    drive_word_t typed_word;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = hptc_pkg::CFG_TARGET_HEADING;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.gyro_main = '0;
    in_ch.gyro_inverted = '0;
    in_ch.begin_req = 1'b0;
    errors = 0;
    words_sent = 0;
    results_checked = 0;
    settled_seen = 0;
    clipped_seen = 0;
    settings_used = 1;
    burst_left = 0;
    aim_q8 = hptc_pkg::TARGET_RST;
    power_cap_pct = hptc_pkg::SPEED_RST;
    kp = hptc_pkg::PGAIN_RST;
    ki = hptc_pkg::IGAIN_RST;
    kd = hptc_pkg::DGAIN_RST;
    integ_band = hptc_pkg::WINDOW_RST;
    integ_limit = hptc_pkg::CAP_RST;
    last_err_q8 = longint'(hptc_pkg::PREV_ERR_RST);
    integ_acc = 0;
    turn_done = 1'b0;

    // reset settings: gyro extremes fold and saturate, then settle and hold
    row_typed(12'd4095, 12'd0, 1'b0, -16'sd15360, 1'b0);
    row_typed(12'd0, 12'd4095, 1'b0, 16'sd15360, 1'b0);
    row_word(12'd0, 12'd0, 1'b0);
    row_typed(12'd0, 12'd0, 1'b0, 16'sd0, 1'b1);
    row_typed(12'd4095, 12'd4095, 1'b0, 16'sd0, 1'b1);
    row_typed(12'd4095, 12'd0, 1'b0, 16'sd0, 1'b1);
    row_word(12'd0, 12'd0, 1'b1);
    row_typed(12'd19, 12'd0, 1'b0, 16'sd0, 1'b1);
    row_word(12'd20, 12'd0, 1'b1);
    row_word(12'd0, 12'd19, 1'b0);
    row_word(12'd0, 12'd20, 1'b0);
    // error folds past a full turn, and the fold boundary itself
    row_reg(hptc_pkg::CFG_TARGET_HEADING, {5'd0, 18'(92160)});
    row_reg(hptc_pkg::CFG_SPEED_LIMIT, 23'd100);
    row_typed(12'd0, 12'd4095, 1'b1, -16'sd25600, 1'b0);
    row_typed(12'd4095, 12'd0, 1'b0, 16'sd25600, 1'b0);
    row_reg(hptc_pkg::CFG_TARGET_HEADING, {5'd0, 18'(-92160)});
    row_typed(12'd4095, 12'd0, 1'b1, 16'sd25600, 1'b0);
    // integral term alone: clamp, unwind, settle
    row_reg(hptc_pkg::CFG_TARGET_HEADING, 23'd0);
    row_reg(hptc_pkg::CFG_PROP_GAIN, 23'd0);
    row_reg(hptc_pkg::CFG_DERIV_GAIN, 23'd0);
    row_reg(hptc_pkg::CFG_INTEG_GAIN, 23'd65536);
    row_typed(12'd0, 12'd200, 1'b1, 16'sd2560, 1'b0);
    row_typed(12'd0, 12'd200, 1'b0, 16'sd3840, 1'b0);
    row_typed(12'd200, 12'd0, 1'b0, 16'sd1280, 1'b0);
    row_typed(12'd0, 12'd0, 1'b0, 16'sd1280, 1'b0);
    row_typed(12'd0, 12'd0, 1'b0, 16'sd0, 1'b1);
    row_typed(12'd0, 12'd200, 1'b1, 16'sd2560, 1'b0);
    // zero error over a lowered cap clamps to the negative side
    row_reg(hptc_pkg::CFG_INTEG_CAP, 23'd1000);
    row_typed(12'd0, 12'd0, 1'b0, -16'sd1000, 1'b0);
    row_reg(hptc_pkg::CFG_SPEED_LIMIT, 23'd0);
    row_typed(12'd0, 12'd200, 1'b0, 16'sd0, 1'b0);
    // speed limit above 100 with the largest gain
    row_reg(hptc_pkg::CFG_SPEED_LIMIT, 23'd127);
    row_reg(hptc_pkg::CFG_PROP_GAIN, 23'h7FFFFF);
    row_typed(12'd0, 12'd4095, 1'b1, 16'sd32512, 1'b0);
    row_typed(12'd4095, 12'd0, 1'b0, -16'sd32512, 1'b0);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan_rows[i]) begin
      r = plan_rows[i];
      if (r.kind == ROW_REG) begin
        settle_pipe();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        typed_word = '{r.left, -r.left, r.settled};
        send_word(r.gm, r.gi, r.beg, r.typed, typed_word);
      end
    end
    if (plan_rows.size() != 0) settings_used++;

    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      run_phase(PHASE_WORDS);
    end

    in_ch.valid = 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (4 * PIPE_LAT) @(posedge clk_i);
    $display("covered %0d words over %0d register settings, %0d results checked",
             words_sent, settings_used, results_checked);
    $display("%0d settled results, %0d words clipped to the speed limit",
             settled_seen, clipped_seen);
    if (errors == 0)
      $display("heading_pid_turn_controller_test: done, clean");
    else
      $display("heading_pid_turn_controller_test: done, errors");
    $finish;
  end

  initial begin : result_check
    drive_word_t want;
    forever begin
      @(posedge clk_i);
      if ((out_ch.valid & out_ch.ready) === 1'b1) begin
        if (pending_drive_q.size() == 0) begin
          $display("%0t unexpected word: left %0d right %0d settled %0b", $time,
                   out_ch.left_power, out_ch.right_power, out_ch.settled);
          errors++;
        end else begin
          want = pending_drive_q.pop_front();
          results_checked++;
          if (out_ch.settled === 1'b1) settled_seen++;
          if (out_ch.left_power !== want.left_power) begin
            $display("%0t left_power expected %0d got %0d", $time, want.left_power,
                     out_ch.left_power);
            errors++;
          end
          if (out_ch.right_power !== want.right_power) begin
            $display("%0t right_power expected %0d got %0d", $time, want.right_power,
                     out_ch.right_power);
            errors++;
          end
          if (out_ch.settled !== want.settled) begin
            $display("%0t settled expected %0b got %0b", $time, want.settled,
                     out_ch.settled);
            errors++;
          end
        end
      end
    end
  end

  // receiver: free-running window, then random stalls with the odd long one
  initial begin : result_stall
    int hold_left;
    int span;
    hold_left = 0;
    span = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      span = (span == 399) ? 0 : span + 1;
      if (span < 120) begin
        out_ch.ready = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 2) != 0);
        hold_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (((in_ch.valid & in_ch.ready) | (out_ch.valid & out_ch.ready)) === 1'b1)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("heading_pid_turn_controller_test: done, errors");
    $finish;
  end

endmodule

>>> heading_pid_turn_controller.f
+incdir+hw/rtl
hw/rtl/hptc_pkg.sv
hw/rtl/hptc_in_if.sv
hw/rtl/hptc_out_if.sv
hw/rtl/heading_pid_turn_controller.sv
tb/heading_pid_turn_controller_test.sv
